>>> sv/pcihbs_pkg.sv
package pcihbs_pkg;

  localparam int unsigned POS_W   = 18;
  localparam int unsigned SPC_W   = 11;
  localparam int unsigned HLEN_W  = 5;
  localparam int unsigned BCNT_W  = 15;
  localparam int unsigned PCI_W   = 24;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned QUO_W   = 13;
  localparam int unsigned NUM_W   = 14;
  localparam int unsigned RCP_W   = 17;
  localparam int unsigned RCP_SH  = 18;

  // register indexes
  localparam logic [IDX_W-1:0] REG_FRAME_SIZE = 8'd0;
  localparam logic [IDX_W-1:0] REG_PCI_WORD   = 8'd1;

  localparam logic [POS_W-1:0]  POS_MAX      = 18'd262143;
  localparam logic [POS_W-1:0]  FS_RESET     = 18'd146176;
  localparam logic [POS_W-1:0]  FS_LARGE     = 18'd72000;
  localparam logic [POS_W-1:0]  OFS_ALIGNED  = 18'd30000;
  localparam logic [POS_W-1:0]  OFS_ODD      = 18'd29999;
  localparam logic [POS_W-1:0]  START_SMALL  = 18'd120;
  localparam logic [POS_W-1:0]  FS_OVERHEAD  = 18'd22;
  localparam logic [SPC_W-1:0]  SPC_24       = 11'd1247;
  localparam logic [SPC_W-1:0]  SPC_23       = 11'd1303;
  localparam logic [SPC_W-1:0]  SPC_22       = 11'd1359;
  localparam logic [SPC_W-1:0]  SPC_MAX      = 11'd2047;
  localparam logic [HLEN_W-1:0] HLEN_24      = 5'd24;
  localparam logic [HLEN_W-1:0] HLEN_23      = 5'd23;
  localparam logic [HLEN_W-1:0] HLEN_22      = 5'd22;
  localparam logic [14:0]       BYTES_24     = 15'd24;
  localparam logic [14:0]       BYTES_14     = 15'd14;

  // reciprocals scaled by 2^18, exact for numerators below 2^14
  localparam logic [RCP_W-1:0]  RCP_3        = 17'd87382;
  localparam logic [RCP_W-1:0]  RCP_22       = 17'd11916;
  localparam logic [RCP_W-1:0]  RCP_23       = 17'd11398;

  typedef struct packed {
    logic [POS_W-1:0]  start;
    logic [SPC_W-1:0]  spacing;
    logic [HLEN_W-1:0] hdr_len;
    logic [BCNT_W-1:0] frame_bytes;
  } frame_cfg_t;

endpackage

>>> sv/pci_header_bit_spreader.sv
// datapath: a taken byte is held in byte_r, and each word it gives is registered
// throughput: one word per cycle from the bit serializer unless out_ready stalls;
//   a byte gives 8 to 16 words; the next is taken as its last word is emitted
// reset: synchronous, active low; frame counters cleared, frame size 146176
//   (capped at MAX_FRAME_BITS), header word zero; input held off after reset and
//   after each frame size write while derived values settle in s1_r and s2_r
module pci_header_bit_spreader #(
  parameter int unsigned MAX_FRAME_BITS = 146176
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_bit,
  output logic                          out_is_header,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pcihbs_pkg::IDX_W-1:0]  cfg_index,
  input  logic [pcihbs_pkg::PCI_W-1:0]  cfg_data
);
  import pcihbs_pkg::*;

  frame_cfg_t        frame_cfg;
  logic [PCI_W-1:0]  pci_word;
  logic              restart, busy, can_load, load;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy && !cfg_valid && can_load;
  assign load      = in_valid && in_ready;

  pcihbs_cfg #(
    .MAX_FRAME_BITS(MAX_FRAME_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_valid && cfg_ready),
    .wr_idx    (cfg_index),
    .wr_data   (cfg_data),
    .frame_cfg (frame_cfg),
    .pci_word  (pci_word),
    .restart   (restart),
    .busy      (busy)
  );

  pcihbs_ser u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .frame_cfg     (frame_cfg),
    .pci_word      (pci_word),
    .restart       (restart),
    .load          (load),
    .load_byte     (in_data_byte),
    .can_load      (can_load),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_bit       (out_bit),
    .out_is_header (out_is_header),
    .out_last      (out_last)
  );
endmodule

>>> sv/pcihbs_cfg.sv
module pcihbs_cfg #(
  parameter int unsigned MAX_FRAME_BITS = 146176
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [pcihbs_pkg::IDX_W-1:0]  wr_idx,
  input  logic [pcihbs_pkg::PCI_W-1:0]  wr_data,
  output pcihbs_pkg::frame_cfg_t        frame_cfg,
  output logic [pcihbs_pkg::PCI_W-1:0]  pci_word,
  output logic                          restart,
  output logic                          busy
);
  import pcihbs_pkg::*;

  localparam logic [POS_W-1:0] FS_MAX = POS_W'(MAX_FRAME_BITS);
  localparam logic [POS_W-1:0] FS_INIT = (FS_RESET > FS_MAX) ? FS_MAX : FS_RESET;

  logic [POS_W-1:0]  fs_r, fs_nxt;
  logic [PCI_W-1:0]  pci_r;
  logic              s1_r, s2_r;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [RCP_W-1:0]  rcp_r, rcp_nxt;
  logic              ok_r, ok_nxt;
  frame_cfg_t        cfg_r, cfg_nxt;

  logic              wr_fs;
  logic [14:0]       fs8;
  logic              m0, m7, big_fs;
  logic [NUM_W+RCP_W-1:0] prod;
  logic [QUO_W-1:0]  quo;
  logic [15:0]       spc_raw;
  logic [POS_W-1:0]  fb_raw;

  assign wr_fs  = wr_en && (wr_idx == REG_FRAME_SIZE);
  assign fs8    = fs_r[POS_W-1:3];
  assign m0     = (fs_r[2:0] == 3'd0);
  assign m7     = (fs_r[2:0] == 3'd7);
  assign big_fs = (fs_r >= FS_LARGE);

  always_comb begin
    fs_nxt = (wr_data[POS_W-1:0] > FS_MAX) ? FS_MAX : wr_data[POS_W-1:0];
  end

  // stage 1: numerator and reciprocal select
  always_comb begin
    if (m0) begin
      ok_nxt  = (fs8 >= BYTES_24);
      num_nxt = NUM_W'(fs8 - BYTES_24);
      rcp_nxt = RCP_3;
    end else begin
      ok_nxt  = (fs8 > BYTES_14);
      num_nxt = NUM_W'(fs8 - BYTES_14);
      rcp_nxt = m7 ? RCP_23 : RCP_22;
    end
  end

  // stage 2: quotient, spacing and the rest
  assign prod = num_r * rcp_r;
  assign quo  = prod[NUM_W+RCP_W-1:RCP_SH];

  always_comb begin
    if (!ok_r || (quo == '0)) begin
      spc_raw = '0;
    end else if (m0) begin
      spc_raw = 16'(quo) - 16'd1;
    end else begin
      spc_raw = {quo, 3'b000} - 16'd1;
    end
    fb_raw = (fs_r >= FS_OVERHEAD) ? ((fs_r - FS_OVERHEAD) >> 3) : '0;

    cfg_nxt.hdr_len     = m0 ? HLEN_24 : (m7 ? HLEN_23 : HLEN_22);
    cfg_nxt.frame_bytes = (fb_raw == '0) ? BCNT_W'(1) : fb_raw[BCNT_W-1:0];
    if (big_fs) begin
      cfg_nxt.start   = m0 ? (fs_r - OFS_ALIGNED) : ({fs8, 3'b000} - OFS_ODD);
      cfg_nxt.spacing = m0 ? SPC_24 : (m7 ? SPC_23 : SPC_22);
    end else begin
      cfg_nxt.start   = START_SMALL;
      cfg_nxt.spacing = (spc_raw > 16'(SPC_MAX)) ? SPC_MAX : spc_raw[SPC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r  <= FS_INIT;
      pci_r <= '0;
      s1_r  <= 1'b1;
      s2_r  <= 1'b0;
    end else begin
      s1_r <= wr_fs;
      s2_r <= s1_r;
      if (wr_fs) begin
        fs_r <= fs_nxt;
      end
      if (wr_en && (wr_idx == REG_PCI_WORD)) begin
        pci_r <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_r) begin
      num_r <= num_nxt;
      rcp_r <= rcp_nxt;
      ok_r  <= ok_nxt;
    end
    if (s2_r) begin
      cfg_r <= cfg_nxt;
    end
  end

  assign frame_cfg = cfg_r;
  assign pci_word  = pci_r;
  assign restart   = wr_fs;
  assign busy      = s1_r || s2_r;

  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    s2_r |-> $past(s1_r)) else $error("derive stage 2 without stage 1");
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !$past(busy)) |-> (cfg_r.hdr_len >= HLEN_22 && cfg_r.hdr_len <= HLEN_24))
    else $error("header length out of range");
  a_fb_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !$past(busy)) |-> (cfg_r.frame_bytes != '0))
    else $error("frame byte count is zero");
endmodule

>>> sv/pcihbs_ser.sv
module pcihbs_ser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pcihbs_pkg::frame_cfg_t        frame_cfg,
  input  logic [pcihbs_pkg::PCI_W-1:0]  pci_word,
  input  logic                          restart,
  input  logic                          load,
  input  logic [7:0]                    load_byte,
  output logic                          can_load,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_bit,
  output logic                          out_is_header,
  output logic                          out_last
);
  import pcihbs_pkg::*;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [HLEN_W-1:0] hc_r, hc_nxt;
  logic [BCNT_W-1:0] bc_r, bc_nxt;
  logic [SPC_W-1:0]  ph_r, ph_nxt;
  logic              cur_v_r;
  logic [7:0]        byte_r;
  logic [2:0]        j_r;
  logic              hdone_r;
  logic              out_v_r, bit_r, hdr_r, last_r;

  logic adv, emit, hdr, fin, past_start;
  logic [BCNT_W-1:0] bc_inc;

  assign adv        = !out_v_r || out_ready;
  assign emit       = adv && cur_v_r;
  assign past_start = (pos_r >= frame_cfg.start);
  assign hdr        = past_start && (hc_r < frame_cfg.hdr_len) && (ph_r == '0) && !hdone_r;
  assign fin        = emit && !hdr && (j_r == 3'd7);
  assign can_load   = !cur_v_r || fin;
  assign bc_inc     = bc_r + BCNT_W'(1);

  always_comb begin
    pos_nxt = pos_r;
    ph_nxt  = ph_r;
    hc_nxt  = hc_r;
    bc_nxt  = bc_r;
    if (emit) begin
      if (past_start) begin
        ph_nxt = (ph_r >= frame_cfg.spacing) ? '0 : ph_r + SPC_W'(1);
      end
      pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + POS_W'(1);
      if (hdr) begin
        hc_nxt = hc_r + HLEN_W'(1);
      end
    end
    if (fin) begin
      if (bc_inc >= frame_cfg.frame_bytes) begin
        pos_nxt = '0;
        ph_nxt  = '0;
        hc_nxt  = '0;
        bc_nxt  = '0;
      end else begin
        bc_nxt = bc_inc;
      end
    end
    if (restart) begin
      pos_nxt = '0;
      ph_nxt  = '0;
      hc_nxt  = '0;
      bc_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      ph_r    <= '0;
      hc_r    <= '0;
      bc_r    <= '0;
      cur_v_r <= 1'b0;
      hdone_r <= 1'b0;
      j_r     <= '0;
      out_v_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      ph_r  <= ph_nxt;
      hc_r  <= hc_nxt;
      bc_r  <= bc_nxt;
      if (load) begin
        cur_v_r <= 1'b1;
        j_r     <= '0;
        hdone_r <= 1'b0;
      end else begin
        if (fin) begin
          cur_v_r <= 1'b0;
        end
        if (emit) begin
          if (hdr) begin
            hdone_r <= 1'b1;
          end else begin
            hdone_r <= 1'b0;
            j_r     <= j_r + 3'd1;
          end
        end
      end
      if (adv) begin
        out_v_r <= cur_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= load_byte;
    end
    if (emit) begin
      hdr_r  <= hdr;
      bit_r  <= hdr ? pci_word[hc_r] : byte_r[3'd7 - j_r];
      last_r <= !hdr && (j_r == 3'd7);
    end
  end

  assign out_valid     = out_v_r;
  assign out_bit       = bit_r;
  assign out_is_header = hdr_r;
  assign out_last      = last_r;

  a_hc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hc_r <= HLEN_24) else $error("header count past maximum");
  a_hdr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && hdr_r) |-> !last_r) else $error("header word flagged last");
  a_bc_step: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> (bc_r == '0) || (bc_r == $past(bc_r) + BCNT_W'(1)))
    else $error("byte count step wrong");
  a_hdr_then_data: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && hdr && !restart) |=> (cur_v_r && hdone_r))
    else $error("header word not followed by data word");
endmodule

>>> tb/sv/pci_header_bit_spreader_tb.sv
`timescale 1ns / 100ps

module pci_header_bit_spreader_tb;
  import pcihbs_pkg::*;

  localparam int unsigned FRAME_CAP = 146176;
  localparam logic [IDX_W-1:0] REG_SPARE = 8'd2;
  localparam logic [IDX_W-1:0] REG_TOP = 8'hFF;
  localparam logic [63:0] CORNER_BYTES = 64'h00FF_AA55_8001_7FFE;

  typedef struct packed {
    logic data;
    logic hdr;
    logic last;
  } spread_bit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_data_byte = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_bit;
  logic out_is_header;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [PCI_W-1:0] cfg_data = '0;

  // frame tracking mirrored from the block
  int unsigned fs_cur;
  logic [PCI_W-1:0] pci_cur;
  int unsigned pos, hdr_cnt, byte_cnt, phase, start_pos, spc, hlen;

  spread_bit_t expected_bits[$];
  spread_bit_t want;
  bit failed = 1'b0;
  bit idle_on = 1'b1;
  int stall_left = 0;

  pci_header_bit_spreader #(
    .MAX_FRAME_BITS(FRAME_CAP)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data_byte(in_data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_bit(out_bit),
    .out_is_header(out_is_header),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic void restart_frame();
    pos = 0;
    hdr_cnt = 0;
    byte_cnt = 0;
    phase = 0;
  endfunction

  // start, spacing and header length from the frame size table
  function automatic void load_frame_size(input logic [PCI_W-1:0] v);
    int s, m, sp, q, d;
    s = int'(v[POS_W-1:0]);
    if (s > int'(FRAME_CAP)) s = int'(FRAME_CAP);
    fs_cur = s;
    m = s % 8;
    if (s >= 72000) begin
      if (m == 0) begin
        start_pos = s - 30000;
        sp = 1247;
        hlen = 24;
      end else begin
        start_pos = 8 * (s / 8) - 29999;
        sp = (m == 7) ? 1303 : 1359;
        hlen = (m == 7) ? 23 : 22;
      end
    end else begin
      start_pos = 120;
      if (m == 0) begin
        sp = (s >= 192) ? ((s - 192) / 24 - 1) : -1;
        hlen = 24;
      end else begin
        q = s / 8 - 14;
        d = (m == 7) ? 23 : 22;
        sp = (q > 0) ? ((q / d) * 8 - 1) : -1;
        hlen = d;
      end
    end
    if (sp < 0) sp = 0;
    if (sp > 2047) sp = 2047;
    spc = sp;
    restart_frame();
  endfunction

  function automatic void advance_pos();
    if (pos >= start_pos) phase = (phase >= spc) ? 0 : phase + 1;
    if (pos < POS_MAX) pos++;
  endfunction

  function automatic void spread_byte(input logic [7:0] b);
    int unsigned nbytes;
    for (int j = 0; j < 8; j++) begin
      if (pos >= start_pos && hdr_cnt < hlen && phase == 0) begin
        expected_bits.push_back('{pci_cur[hdr_cnt], 1'b1, 1'b0});
        hdr_cnt++;
        advance_pos();
      end
      expected_bits.push_back('{b[7-j], 1'b0, (j == 7)});
      advance_pos();
    end
    byte_cnt++;
    nbytes = (fs_cur >= 22) ? (fs_cur - 22) / 8 : 0;
    if (nbytes < 1) nbytes = 1;
    if (byte_cnt >= nbytes) restart_frame();
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(1, 2);
    if (r < 19) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic note_mismatch(input string what, input int exp_v, input int got_v);
    failed = 1'b1;
    $display("%0t %s: expected %0d, actual %0d", $time, what, exp_v, got_v);
  endtask

  // result side: random stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_bits.size() == 0) begin
        failed = 1'b1;
        $display("%0t word with none expected: expected none, actual bit=%0b hdr=%0b last=%0b",
                 $time, out_bit, out_is_header, out_last);
      end else begin
        want = expected_bits.pop_front();
        if (out_bit !== want.data) note_mismatch("out_bit", want.data, out_bit);
        if (out_is_header !== want.hdr) note_mismatch("out_is_header", want.hdr, out_is_header);
        if (out_last !== want.last) note_mismatch("out_last", want.last, out_last);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    spread_byte(b);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [PCI_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_FRAME_SIZE) load_frame_size(val);
    else if (idx == REG_PCI_WORD) pci_cur = val;
  endtask

  // wait for every expected word, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_bits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_byte(rand_byte());
  endtask

  task automatic test_reset_state();
    for (int i = 0; i < 8; i++) send_byte(CORNER_BYTES[8*i +: 8]);
    drain();
  endtask

  // zero spacing: a header word ahead of every data word once past start, until all header words are out
  task automatic test_dense_headers();
    write_reg(REG_FRAME_SIZE, 24'd200);
    write_reg(REG_PCI_WORD, 24'h5AC33C);
    for (int i = 0; i < 24; i++)
      send_byte(i < 8 ? CORNER_BYTES[8*i +: 8] : rand_byte());
    drain();
  endtask

  task automatic test_short_frames();
    // upper bits of the size are dropped
    write_reg(REG_FRAME_SIZE, 24'hFC0019);
    write_reg(REG_SPARE, 24'hFFFFFF);
    write_reg(REG_TOP, 24'h000000);
    send_random(4);
    drain();
    write_reg(REG_FRAME_SIZE, 24'd0);
    send_random(3);
    drain();
    write_reg(REG_FRAME_SIZE, 24'd150);
    write_reg(REG_PCI_WORD, 24'hFFFFFF);
    send_random(17);
    drain();
    write_reg(REG_FRAME_SIZE, 24'd167);
    write_reg(REG_PCI_WORD, 24'h000000);
    send_random(19);
    drain();
  endtask

  task automatic test_min_frame();
    write_reg(REG_FRAME_SIZE, 24'd2304);
    write_reg(REG_PCI_WORD, 24'hFFFFFF);
    send_random(100);
    drain();
  endtask

  task automatic test_spacing_saturation();
    int sizes [3];
    sizes = '{71992, 71999, 71995};
    for (int k = 0; k < 3; k++) begin
      write_reg(REG_FRAME_SIZE, PCI_W'(sizes[k]));
      write_reg(REG_PCI_WORD, PCI_W'($urandom_range(0, 24'hFFFFFF)));
      send_random(20);
      drain();
    end
  endtask

  // large frames, with bytes sent back to back and no output stalls
  task automatic test_large_frames();
    int sizes [4];
    int counts [4];
    sizes = '{72000, 72007, 72003, 24'h03FFFF};
    counts = '{6, 6, 6, 6};
    idle_on = 1'b0;
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_FRAME_SIZE, PCI_W'(sizes[k]));
      write_reg(REG_PCI_WORD, PCI_W'($urandom_range(0, 24'hFFFFFF)));
      send_random(counts[k]);
      drain();
    end
    idle_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int fs;
    logic [PCI_W-1:0] pw;
    for (int k = 0; k < 8; k++) begin
      case ($urandom_range(0, 3))
        0: fs = 8 * $urandom_range(24, 150);
        1: fs = 8 * $urandom_range(30, 150) + 7;
        2: fs = 8 * $urandom_range(30, 150) + $urandom_range(1, 6);
        default: fs = $urandom_range(0, 250);
      endcase
      if (k == 0) pw = 24'h000000;
      else if (k == 1) pw = 24'hFFFFFF;
      else pw = PCI_W'($urandom_range(0, 24'hFFFFFF));
      idle_on = (k % 4) != 3;
      write_reg(REG_FRAME_SIZE, PCI_W'(fs));
      write_reg(REG_PCI_WORD, pw);
      send_random(20);
      drain();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    pci_cur = '0;
    load_frame_size(PCI_W'(FS_RESET));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_dense_headers();
    test_short_frames();
    test_min_frame();
    test_spacing_saturation();
    test_random_frames();
    test_large_frames();
    drain();
    if (failed) begin
      $display("SCOREBOARD MISMATCH");
    end else begin
      $display("SCOREBOARD CLEAN");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
